>>> hdl/asgr_pkg.sv
`timescale 1ns / 1ps

package asgr_pkg;

  // Parser states, one-hot
  typedef enum logic [5:0] {
    ST_WAIT_ESC = 6'b000001,
    ST_WAIT_BRK = 6'b000010,
    ST_GROUP    = 6'b000100,
    ST_FG       = 6'b001000,
    ST_BG       = 6'b010000,
    ST_END      = 6'b100000
  } parse_state_t;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_FOUR   = 8'h34;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  localparam logic [7:0] STYLE_DEFAULT = 8'h0F;
  localparam logic [7:0] STYLE_CLEAR   = 8'h00;

  // Parser context: everything that carries from one word to the next
  typedef struct packed {
    parse_state_t state;
    logic [7:0]   current_style;
    logic [7:0]   pending_style;
  } parse_ctx_t;

  // ANSI color index to VGA color index
  function automatic logic [2:0] vga_perm(input logic [2:0] ansi);
    logic [2:0] vga;
    case (ansi)
      3'd0: vga = 3'd0;
      3'd1: vga = 3'd4;
      3'd2: vga = 3'd2;
      3'd3: vga = 3'd6;
      3'd4: vga = 3'd1;
      3'd5: vga = 3'd5;
      3'd6: vga = 3'd3;
      3'd7: vga = 3'd7;
      default: vga = 3'd0;
    endcase
    return vga;
  endfunction

endpackage

>>> hdl/asgr_if.sv
`timescale 1ns / 1ps

interface asgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface asgr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] style_out;
  logic [7:0] char_out;

  modport source (output valid, output style_out, output char_out, input ready);
  modport sink (input valid, input style_out, input char_out, output ready);
endinterface

>>> hdl/asgr_step.sv
`timescale 1ns / 1ps

module asgr_step
  import asgr_pkg::*;
(
  input  parse_ctx_t ctx,
  input  logic [7:0] char_in,
  output parse_ctx_t ctx_next,
  output logic [7:0] char_out
);

  logic       is_digit;
  logic [2:0] vga_color;

  assign is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_SEVEN);
  assign vga_color = vga_perm(char_in[2:0]);

  always_comb begin
    ctx_next = ctx;
    char_out = 8'h00;
    case (ctx.state)
      ST_WAIT_BRK: begin
        if (char_in == CH_LBRACK) begin
          ctx_next.state = ST_GROUP;
        end else begin
          ctx_next.state = ST_WAIT_ESC;
          char_out       = char_in;
        end
      end
      ST_GROUP: begin
        if (char_in == CH_THREE) begin
          ctx_next.state = ST_FG;
        end else if (char_in == CH_FOUR) begin
          ctx_next.state = ST_BG;
        end else if (char_in == CH_ZERO) begin
          ctx_next.state         = ST_END;
          ctx_next.pending_style = STYLE_DEFAULT;
        end else begin
          ctx_next.state         = ST_WAIT_ESC;
          ctx_next.pending_style = STYLE_CLEAR;
          char_out               = char_in;
        end
      end
      ST_FG: begin
        if (is_digit) begin
          ctx_next.state         = ST_END;
          ctx_next.pending_style = {ctx.pending_style[7:4], 1'b0, vga_color};
        end else begin
          ctx_next.state         = ST_WAIT_ESC;
          ctx_next.pending_style = STYLE_CLEAR;
          char_out               = char_in;
        end
      end
      ST_BG: begin
        if (is_digit) begin
          ctx_next.state         = ST_END;
          ctx_next.pending_style = {1'b0, vga_color, ctx.pending_style[3:0]};
        end else begin
          ctx_next.state         = ST_WAIT_ESC;
          ctx_next.pending_style = STYLE_CLEAR;
          char_out               = char_in;
        end
      end
      ST_END: begin
        if (char_in == CH_SEMI) begin
          ctx_next.state = ST_GROUP;
        end else if (char_in == CH_M) begin
          // commit the collected style
          ctx_next.state         = ST_WAIT_ESC;
          ctx_next.current_style = ctx.pending_style;
          ctx_next.pending_style = STYLE_CLEAR;
        end else begin
          ctx_next.state         = ST_WAIT_ESC;
          ctx_next.pending_style = STYLE_CLEAR;
          char_out               = char_in;
        end
      end
      default: begin
        // waiting for escape
        if (char_in == CH_ESC) begin
          ctx_next.state = ST_WAIT_BRK;
        end else begin
          ctx_next.state = ST_WAIT_ESC;
          char_out       = char_in;
        end
      end
    endcase
  end

endmodule

>>> hdl/ansi_sgr_color_parser_unit.sv
`timescale 1ns / 1ps

// ANSI SGR color parser.
// in_ch carries one character per word; out_ch returns one word per input
// word: style_out is the attribute byte current before that character
// (background high nibble, foreground low nibble) and char_out is the
// character to show, or zero if an escape sequence swallowed it.
// Recognized: ESC '[' group {';' group} 'm', group = '0', '3'd or '4'd with
// d in '0'..'7'. A malformed sequence is dropped and the breaking character
// is passed through.
// The result is registered, valid in the cycle after the accepting edge.
// Throughput: one word per cycle while out_ch.ready holds; the whole parse
// step sits between the parser state registers and the result register.
// Reset: parser waits for escape, style 0x0F, pending style cleared, no
// result held, in_ch.ready low while rst is high.
// Stall: a held result keeps its value; in_ch.ready follows out_ch.ready
// combinationally, so a new word is taken in the same cycle the held one
// leaves.
module ansi_sgr_color_parser_unit
  import asgr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  asgr_in_if.sink    in_ch,
  asgr_out_if.source out_ch
);

  parse_ctx_t ctx;
  parse_ctx_t ctx_next;
  logic [7:0] step_char;
  logic       out_valid;
  logic [7:0] style_reg;
  logic [7:0] char_reg;
  logic       accept;

  assign in_ch.ready = !rst && (!out_valid || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  asgr_step u_step (
    .ctx      (ctx),
    .char_in  (in_ch.char_in),
    .ctx_next (ctx_next),
    .char_out (step_char)
  );

  // parser context
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state         <= ST_WAIT_ESC;
      ctx.current_style <= STYLE_DEFAULT;
      ctx.pending_style <= STYLE_CLEAR;
    end else if (accept) begin
      ctx <= ctx_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload: style before this word, plus passed-through char
  always_ff @(posedge clk) begin
    if (accept) begin
      style_reg <= ctx.current_style;
      char_reg  <= step_char;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.style_out = style_reg;
  assign out_ch.char_out  = char_reg;

  // ---------------------------------------------------------------------
  // checks

  // pending style is only nonzero inside a sequence body
  a_pending_idle: assert property (@(posedge clk) disable iff (rst)
    (ctx.state == ST_WAIT_ESC || ctx.state == ST_WAIT_BRK)
      |-> ctx.pending_style == STYLE_CLEAR)
    else $error("pending style left set outside a sequence");

  // every accepted word yields a result with the style current at accept
  a_style_out: assert property (@(posedge clk) disable iff (rst)
    (!rst && accept) |=> (out_valid && style_reg == $past(ctx.current_style)))
    else $error("result missing or wrong style");

  // current style changes only on a terminating 'm'
  a_style_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && (!accept || in_ch.char_in != CH_M)) |=> $stable(ctx.current_style))
    else $error("current style changed without 'm'");

  // plain text outside a sequence passes through
  a_passthru: assert property (@(posedge clk) disable iff (rst)
    (!rst && accept && ctx.state == ST_WAIT_ESC && in_ch.char_in != CH_ESC)
      |=> char_reg == $past(in_ch.char_in))
    else $error("plain character not passed through");

endmodule

>>> test/ansi_sgr_color_parser_unit_tb.sv
`timescale 1ns / 1ps

module ansi_sgr_color_parser_unit_tb
  import asgr_pkg::*;
();

  // One displayed word: the attribute byte in force and the character shown
  typedef struct packed {
    logic [7:0] style;
    logic [7:0] ch;
  } disp_word_t;

  // Tracks the terminal's color state and the words it must display
  class sgr_scoreboard;
    parse_state_t state;
    logic [7:0]   cur_style;
    logic [7:0]   pend_style;
    logic [2:0]   vga_of [8];
    disp_word_t   shown_q[$];
    int unsigned  fails;

    function new();
      state      = ST_WAIT_ESC;
      cur_style  = STYLE_DEFAULT;
      pend_style = STYLE_CLEAR;
      vga_of     = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
      fails      = 0;
    endfunction

    // Malformed sequence: back to idle, pending colors dropped, byte shown
    function logic [7:0] abandon_seq(logic [7:0] c);
      state      = ST_WAIT_ESC;
      pend_style = STYLE_CLEAR;
      return c;
    endfunction

    function bit is_color_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_SEVEN;
    endfunction

    // Steps the color state for one accepted character
    function void note_char(logic [7:0] c);
      disp_word_t w;
      w.style = cur_style;
      w.ch    = 8'h00;
      case (state)
        ST_WAIT_BRK: begin
          if (c == CH_LBRACK) begin
            state = ST_GROUP;
          end else begin
            state = ST_WAIT_ESC;
            w.ch  = c;
          end
        end
        ST_GROUP: begin
          if (c == CH_THREE) begin
            state = ST_FG;
          end else if (c == CH_FOUR) begin
            state = ST_BG;
          end else if (c == CH_ZERO) begin
            state      = ST_END;
            pend_style = STYLE_DEFAULT;
          end else begin
            w.ch = abandon_seq(c);
          end
        end
        ST_FG: begin
          if (is_color_digit(c)) begin
            state           = ST_END;
            pend_style[3:0] = {1'b0, vga_of[c[2:0]]};
          end else begin
            w.ch = abandon_seq(c);
          end
        end
        ST_BG: begin
          if (is_color_digit(c)) begin
            state           = ST_END;
            pend_style[7:4] = {1'b0, vga_of[c[2:0]]};
          end else begin
            w.ch = abandon_seq(c);
          end
        end
        ST_END: begin
          if (c == CH_SEMI) begin
            state = ST_GROUP;
          end else if (c == CH_M) begin
            state      = ST_WAIT_ESC;
            cur_style  = pend_style;
            pend_style = STYLE_CLEAR;
          end else begin
            w.ch = abandon_seq(c);
          end
        end
        default: begin
          if (c == CH_ESC) begin
            state = ST_WAIT_BRK;
          end else begin
            state = ST_WAIT_ESC;
            w.ch  = c;
          end
        end
      endcase
      shown_q.push_back(w);
    endfunction

    function void check_word(logic [7:0] style, logic [7:0] ch);
      disp_word_t w;
      if (shown_q.size() == 0) begin
        $error("unexpected word: style_out %h, char_out %h", style, ch);
        fails++;
        return;
      end
      w = shown_q.pop_front();
      if (style !== w.style) begin
        $error("style_out: expected %h, got %h", w.style, style);
        fails++;
      end
      if (ch !== w.ch) begin
        $error("char_out: expected %h, got %h", w.ch, ch);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return shown_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  asgr_in_if  in_ch();
  asgr_out_if out_ch();

  ansi_sgr_color_parser_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sgr_scoreboard sb = new();

  int unsigned chars_sent = 0;
  int unsigned words_taken = 0;
  bit          tx_calm = 1'b1;
  bit          rx_calm = 1'b0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs on either handshake
  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one character after an optional idle gap and waits until it is taken.
  // Called at a rising edge; valid is only lowered when a gap follows, so a
  // back-to-back word never sees two assignments to valid in one step.
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_char(c);
    chars_sent++;
    // switch between bursts with no idling and bursts with random gaps
    if (chars_sent % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
  endtask

  task automatic send_str(input logic [7:0] s[$]);
    foreach (s[i]) send_char(s[i]);
  endtask

  // ESC [ group {; group} m with random groups; when cut, the sequence is
  // chopped at a random point and a random byte put there instead
  task automatic send_sgr(input bit cut);
    logic [7:0]  seq[$];
    int unsigned groups;
    int unsigned pos;
    seq = '{CH_ESC, CH_LBRACK};
    groups = $urandom_range(1, 4);
    for (int g = 0; g < groups; g++) begin
      case ($urandom_range(0, 2))
        0: seq.push_back(CH_ZERO);
        1: begin
          seq.push_back(CH_THREE);
          seq.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
        end
        default: begin
          seq.push_back(CH_FOUR);
          seq.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
        end
      endcase
      if (g < groups - 1) seq.push_back(CH_SEMI);
    end
    seq.push_back(CH_M);
    if (cut) begin
      pos = $urandom_range(1, seq.size() - 1);
      seq = seq[0:pos-1];
      // half the time near-miss bytes around the digits, else anything
      if ($urandom_range(0, 1) == 0)
        seq.push_back(8'($urandom_range(8'h2F, 8'h3C)));
      else
        seq.push_back(8'($urandom_range(0, 255)));
    end
    send_str(seq);
  endtask

  // Stimulus and end of run
  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.char_in = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // plain text: printable, zero byte outside a sequence, top code
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    // red foreground
    send_str('{CH_ESC, CH_LBRACK, CH_THREE, 8'h31, CH_M});
    // several groups incl. reset to default, then black-on-black
    send_str('{CH_ESC, CH_LBRACK, CH_FOUR, CH_SEVEN, CH_SEMI, CH_ZERO, CH_SEMI,
               CH_THREE, CH_ZERO, CH_M});
    // escape where '[' is due: escape byte shown
    send_str('{CH_ESC, CH_ESC});
    // bad group character
    send_str('{CH_ESC, CH_LBRACK, 8'h39});
    // color digit out of range
    send_str('{CH_ESC, CH_LBRACK, CH_THREE, 8'h38});

    // random part: half well-formed sequences, mixed with broken ones and noise
    while (chars_sent < 420) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_sgr(1'b0);
        5, 6:          send_sgr(1'b1);
        default:       send_char(8'($urandom_range(0, 255)));
      endcase
    end
    // last word was taken at this edge; drop valid right away
    in_ch.valid <= 1'b0;

    // drain, then give a stray word time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: random stalls, with calm stretches where ready stays high
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_word(out_ch.style_out, out_ch.char_out);
      words_taken++;
      if (words_taken % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
    end
  end

endmodule

>>> filelist.f
hdl/asgr_pkg.sv
hdl/asgr_if.sv
hdl/asgr_step.sv
hdl/ansi_sgr_color_parser_unit.sv
test/ansi_sgr_color_parser_unit_tb.sv
